// ===== rtl/core/iar_pkg.sv =====
// shared types and constants for the integer to ascii radix converter
package iar_pkg;

  // command codes on the input channel
  localparam logic [2:0] CMD_HEX_LOWER = 3'd0;
  localparam logic [2:0] CMD_HEX_UPPER = 3'd1;
  localparam logic [2:0] CMD_OCTAL     = 3'd2;
  localparam logic [2:0] CMD_SIGNED    = 3'd3;
  localparam logic [2:0] CMD_UNSIGNED  = 3'd4;

  localparam int VALUE_W         = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  // radix selection carried from front to back
  typedef enum logic [1:0] {
    RDX_HEX = 2'd0,
    RDX_OCT = 2'd1,
    RDX_DEC = 2'd2
  } radix_t;

  // classified work item: magnitude plus how to print it
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    radix_t             radix;
    logic               upper;
  } desc_t;

endpackage

// ===== rtl/core/iar_front.sv =====
// front end: accepts items, takes the magnitude and drops suppressed zeros and unknown commands
module iar_front (
  input  logic [iar_pkg::VALUE_W-1:0] in_value,
  input  logic [2:0]                  in_command,
  input  logic                        in_zero_precision,
  input  logic                        in_alt_form,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        push_valid,
  input  logic                        push_ready,
  output iar_pkg::desc_t              push_desc
);
  import iar_pkg::*;

  logic               known;
  logic               is_zero;
  logic               keep;
  logic [VALUE_W-1:0] mag;

  assign is_zero = (in_value == '0);

  always_comb begin
    known           = 1'b1;
    push_desc.upper = 1'b0;
    push_desc.radix = RDX_HEX;
    mag             = in_value;
    unique case (in_command)
      CMD_HEX_LOWER: push_desc.radix = RDX_HEX;
      CMD_HEX_UPPER: begin
        push_desc.radix = RDX_HEX;
        push_desc.upper = 1'b1;
      end
      CMD_OCTAL:     push_desc.radix = RDX_OCT;
      CMD_SIGNED: begin
        push_desc.radix = RDX_DEC;
        if (in_value[VALUE_W-1]) begin
          mag = ~in_value + 1'b1;
        end
      end
      CMD_UNSIGNED:  push_desc.radix = RDX_DEC;
      default:       known = 1'b0;
    endcase
    push_desc.mag = mag;
  end

  // zero is silent with zero precision, and in octal with alternate form
  assign keep = known &&
                !(is_zero && (in_zero_precision || (in_command == CMD_OCTAL && in_alt_form)));

  assign in_ready   = push_ready;
  assign push_valid = in_valid && keep;

endmodule

// ===== rtl/core/iar_queue.sv =====
// small first-word-fall-through queue between front and back
module iar_queue #(
  parameter int DEPTH = iar_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_valid,
  output logic                       push_ready,
  input  iar_pkg::desc_t             push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output iar_pkg::desc_t             pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import iar_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  desc_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign count      = count_r;

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/iar_back.sv =====
// back end: digit extraction, leading zero skip and character output
module iar_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  iar_pkg::desc_t pop_data,
  output logic [6:0]     out_character,
  output logic           out_last,
  output logic           out_valid,
  input  logic           out_ready
);
  import iar_pkg::*;

  localparam int DIGITS     = 22;
  localparam int DIG_W      = DIGITS * 4;
  localparam int HEX_DIGITS = 16;
  localparam int DEC_DIGITS = 20;
  localparam int CONV_STEPS = 64;
  localparam logic [6:0] ASCII_ZERO    = 7'd48;
  localparam logic [6:0] ASCII_UPPER_A = 7'd65;
  localparam logic [6:0] ASCII_LOWER_A = 7'd97;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [DIG_W-1:0]   dig_r, dig_nxt;
  logic [5:0]         iter_r, iter_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               upper_r, upper_nxt;
  logic               started_r, started_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [6:0]         out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [DIG_W-1:0]   adj;
  logic [DIG_W-1:0]   oct_load;
  logic [VALUE_W+1:0] oct_pad;
  logic [3:0]         head;
  logic               skip;
  logic               slot_free;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] base;
    base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    if (d <= 4'd9) begin
      return ASCII_ZERO + 7'(d);
    end
    return base + 7'(d) - 7'd10;
  endfunction

  // shift-and-add-3 correction on every bcd digit
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3 : dig_r[4*i +: 4];
    end
  end

  // octal digits spread into nibbles, top digit holds the last value bit
  assign oct_pad = {2'b00, pop_data.mag};
  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      oct_load[4*j +: 4] = {1'b0, oct_pad[3*j +: 3]};
    end
  end

  assign head      = dig_r[DIG_W-1 -: 4];
  assign skip      = !started_r && (head == 4'd0) && (cnt_r != 5'd1);
  assign slot_free = !out_valid_r || out_ready;
  assign pop_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    dig_nxt       = dig_r;
    iter_nxt      = iter_r;
    cnt_nxt       = cnt_r;
    upper_nxt     = upper_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          upper_nxt   = pop_data.upper;
          started_nxt = 1'b0;
          unique case (pop_data.radix)
            RDX_HEX: begin
              dig_nxt   = {pop_data.mag, {(DIG_W-VALUE_W){1'b0}}};
              cnt_nxt   = 5'(HEX_DIGITS);
              state_nxt = ST_OUT;
            end
            RDX_OCT: begin
              dig_nxt   = oct_load;
              cnt_nxt   = 5'(DIGITS);
              state_nxt = ST_OUT;
            end
            RDX_DEC: begin
              dig_nxt   = '0;
              bin_nxt   = pop_data.mag;
              iter_nxt  = 6'(CONV_STEPS-1);
              cnt_nxt   = 5'(DEC_DIGITS);
              state_nxt = ST_CONV;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        dig_nxt  = {adj[DIG_W-2:8], bin_r[VALUE_W-1], 8'b0};
        bin_nxt  = {bin_r[VALUE_W-2:0], 1'b0};
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (skip) begin
          dig_nxt = {dig_r[DIG_W-5:0], 4'b0};
          cnt_nxt = cnt_r - 1'b1;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(head, upper_r);
          out_last_nxt  = (cnt_r == 5'd1);
          dig_nxt       = {dig_r[DIG_W-5:0], 4'b0};
          cnt_nxt       = cnt_r - 1'b1;
          started_nxt   = 1'b1;
          if (cnt_r == 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    dig_r      <= dig_nxt;
    iter_r     <= iter_nxt;
    cnt_r      <= cnt_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/core/integer_to_ascii_radix.sv =====
// top level of the integer to ascii radix converter
//
//   channel   ports                                         direction
//   in        in_value in_command in_zero_precision         sink
//             in_alt_form in_valid in_ready
//   out       out_character out_last out_valid out_ready   source
//
// hex loads and then walks 16 digit slots, octal walks 22 slots, and decimal runs
//   64 shift-and-add-3 steps before it walks 20 slots
// leading zero slots are skipped one per cycle, digits leave one per cycle while out_ready holds
// the double-dabble loop in the back end dominates the decimal conversion time
// rst_n is synchronous active low and empties the queue and output register
// the front keeps accepting into the queue while the back stalls on out_ready, until the queue is full
module integer_to_ascii_radix #(
  parameter int QUEUE_DEPTH = iar_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [iar_pkg::VALUE_W-1:0] in_value,
  input  logic [2:0]                  in_command,
  input  logic                        in_zero_precision,
  input  logic                        in_alt_form,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic [6:0]                  out_character,
  output logic                        out_last,
  output logic                        out_valid,
  input  logic                        out_ready
);
  import iar_pkg::*;

  // classified item heading into the queue
  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;

  // queue head offered to the back end
  logic  pop_valid;
  logic  pop_ready;
  desc_t pop_desc;

  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  // front: sign fold and zero suppression, no state
  iar_front u_front (
    .in_value          (in_value),
    .in_command        (in_command),
    .in_zero_precision (in_zero_precision),
    .in_alt_form       (in_alt_form),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_desc         (push_desc)
  );

  // decoupling queue
  iar_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_desc),
    .count      (q_count)
  );

  // back: digit generation and character transfer
  iar_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_desc),
    .out_character (out_character),
    .out_last      (out_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  // every emitted character is a digit of one of the supported styles
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_character >= 7'd48 && out_character <= 7'd57) ||
                   (out_character >= 7'd65 && out_character <= 7'd70) ||
                   (out_character >= 7'd97 && out_character <= 7'd102)))
    else $error("non-digit character on output");

  // once a number has started, its digits follow without gaps
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("gap inside a digit string");

  // queue occupancy stays within its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QUEUE_DEPTH)
    else $error("queue overflow");

  // reset leaves no transfer pending
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
